[rtl/uart_16550_register_model_unit_assert.svh]
// assertion macros for the checker file
`ifndef UART_16550_REGISTER_MODEL_UNIT_ASSERT_SVH
`define UART_16550_REGISTER_MODEL_UNIT_ASSERT_SVH

// generic clocked assertion with an active-low reset
`define U16550RM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the block clock and reset
`define U16550RM_CHK(lbl, prop, msg) \
    `U16550RM_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

[rtl/u16550rm_pkg.sv]
package u16550rm_pkg;

    localparam int FIFO_DEPTH  = 64;
    localparam int MAX_BACKOFF = 64;
    localparam int FIFO_AW     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
    localparam int BACKOFF_W   = $clog2(MAX_BACKOFF + 1);

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ADDR_RBR = 3'd0,
        ADDR_IER = 3'd1,
        ADDR_IIR = 3'd2,
        ADDR_LCR = 3'd3,
        ADDR_MCR = 3'd4,
        ADDR_LSR = 3'd5,
        ADDR_MSR = 3'd6,
        ADDR_SCR = 3'd7
    } t_reg_addr;

    localparam logic [7:0] LSR_DR       = 8'h01;
    localparam logic [7:0] LSR_TX_EMPTY = 8'h60;
    localparam int         LSR_TEMT_BIT = 6;
    localparam int         LCR_DLAB_BIT = 7;
    localparam int         MCR_LOOP_BIT = 4;
    localparam logic [7:0] MCR_RESET    = 8'h08;
    localparam logic [7:0] MSR_FIXED    = 8'hB0;
    localparam logic [7:0] DLL_RESET    = 8'h0C;
    localparam logic [7:0] IIR_NONE     = 8'h01;
    localparam logic [7:0] IIR_RX       = 8'h04;
    localparam logic [7:0] IIR_TX       = 8'h02;
    localparam logic [7:0] IIR_FORCE    = 8'hC0;
    localparam int         FCR_EN_BIT   = 0;
    localparam int         FCR_RXC_BIT  = 1;
    localparam int         FCR_TXC_BIT  = 2;
    localparam int         IER_RX_BIT   = 0;
    localparam int         IER_TX_BIT   = 1;

endpackage

[rtl/uart_16550_register_model_unit.sv]
// 16550-style uart register block.
// input channel (i_valid / o_ready): one transaction is a register read, a
// register write, a no-op or a clock tick that may offer one host receive byte.
// output channel (o_valid / i_ready): one result transaction per input
// transaction, in order: read data, interrupt level, transmitted byte and
// whether the offered host byte was queued.
// the result is registered and shown in the cycle after its input is accepted.
// throughput: one transaction per cycle unless stalled; all register and
// fifo pointer updates finish in the accept cycle, and the receive fifo ram
// is read in that same cycle so its registered read data lands with the result.
// stall: a single output register holds the result; while it is full and
// i_ready is low, o_ready is low. o_ready is high whenever the output
// register is empty or is being emptied in the same cycle.
// reset: synchronous, active low; all uart registers take their reset
// values, the fifo becomes empty and the output register is emptied. no
// clearing pass is needed.
module uart_16550_register_model_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_opcode,
    input  logic [2:0] i_reg_addr,
    input  logic [7:0] i_write_data,
    input  logic       i_host_byte_valid,
    input  logic [7:0] i_host_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_read_data,
    output logic       o_irq_level,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic       o_host_byte_taken
);

    localparam int AW = u16550rm_pkg::FIFO_AW;
    localparam int CW = u16550rm_pkg::FIFO_CW;
    localparam int BW = u16550rm_pkg::BACKOFF_W;

    logic [AW-1:0] r_rx_head, n_rx_head;
    logic [CW-1:0] r_rx_count, n_rx_count;
    logic [3:0]    r_ier, n_ier;
    logic [7:0]    r_iir, n_iir;
    logic [7:0]    r_fcr, n_fcr;
    logic [7:0]    r_lcr, n_lcr;
    logic [7:0]    r_mcr, n_mcr;
    logic [7:0]    r_lsr, n_lsr;
    logic [7:0]    r_dll, n_dll;
    logic [7:0]    r_dlm, n_dlm;
    logic [7:0]    r_scr, n_scr;
    logic [BW-1:0] r_backoff, n_backoff;
    logic          r_irq, n_irq;

    logic          r_out_valid;
    logic [7:0]    r_rd, n_rd;
    logic          r_rd_ram, n_rd_ram;
    logic          r_txv, n_txv;
    logic [7:0]    r_txb, n_txb;
    logic          r_taken, n_taken;

    logic          in_acc;
    logic          pop;
    logic          push;
    logic [7:0]    push_data;
    logic [CW:0]   push_sum;
    logic [AW-1:0] push_addr;
    logic [AW-1:0] head_inc;
    logic          fifo_full;
    logic          dlab;
    logic          upd;
    logic [7:0]    pend;
    logic [7:0]    ram_q;

    assign o_ready  = !r_out_valid || i_ready;
    assign in_acc   = i_valid && o_ready;
    assign dlab     = r_lcr[u16550rm_pkg::LCR_DLAB_BIT];
    assign fifo_full = (r_rx_count >= CW'(u16550rm_pkg::FIFO_DEPTH));

    assign push_sum = (CW+1)'(r_rx_head) + (CW+1)'(r_rx_count);
    assign push_addr = (push_sum >= (CW+1)'(u16550rm_pkg::FIFO_DEPTH))
        ? AW'(push_sum - (CW+1)'(u16550rm_pkg::FIFO_DEPTH)) : AW'(push_sum);
    assign head_inc = (r_rx_head == AW'(u16550rm_pkg::FIFO_DEPTH - 1))
        ? '0 : r_rx_head + 1'b1;

    always_comb begin
        n_rx_head  = r_rx_head;
        n_rx_count = r_rx_count;
        n_ier      = r_ier;
        n_iir      = r_iir;
        n_fcr      = r_fcr;
        n_lcr      = r_lcr;
        n_mcr      = r_mcr;
        n_lsr      = r_lsr;
        n_dll      = r_dll;
        n_dlm      = r_dlm;
        n_scr      = r_scr;
        n_backoff  = r_backoff;
        n_irq      = r_irq;
        n_rd       = '0;
        n_rd_ram   = 1'b0;
        n_txv      = 1'b0;
        n_txb      = '0;
        n_taken    = 1'b0;
        pop        = 1'b0;
        push       = 1'b0;
        push_data  = i_write_data;
        upd        = 1'b0;
        pend       = '0;
        unique case (u16550rm_pkg::t_opcode'(i_opcode))
            u16550rm_pkg::OP_READ: begin
                unique case (u16550rm_pkg::t_reg_addr'(i_reg_addr))
                    u16550rm_pkg::ADDR_RBR: begin
                        if (dlab) begin
                            n_rd = r_dll;
                        end else if (r_rx_count == '0) begin
                            n_lsr = n_lsr & ~u16550rm_pkg::LSR_DR;
                        end else begin
                            pop        = 1'b1;
                            n_rd_ram   = 1'b1;
                            n_rx_head  = head_inc;
                            n_rx_count = r_rx_count - 1'b1;
                            if (r_rx_count == CW'(1)) begin
                                n_lsr = n_lsr & ~u16550rm_pkg::LSR_DR;
                            end
                        end
                        upd = 1'b1;
                    end
                    u16550rm_pkg::ADDR_IER: n_rd = dlab ? r_dlm : {4'b0, r_ier};
                    u16550rm_pkg::ADDR_IIR: n_rd = r_iir | u16550rm_pkg::IIR_FORCE;
                    u16550rm_pkg::ADDR_LCR: n_rd = r_lcr;
                    u16550rm_pkg::ADDR_MCR: n_rd = r_mcr;
                    u16550rm_pkg::ADDR_LSR: n_rd = r_lsr;
                    u16550rm_pkg::ADDR_MSR: n_rd = u16550rm_pkg::MSR_FIXED;
                    u16550rm_pkg::ADDR_SCR: n_rd = r_scr;
                endcase
            end
            u16550rm_pkg::OP_WRITE: begin
                unique case (u16550rm_pkg::t_reg_addr'(i_reg_addr))
                    u16550rm_pkg::ADDR_RBR: begin
                        if (dlab) begin
                            n_dll = i_write_data;
                        end else if (r_mcr[u16550rm_pkg::MCR_LOOP_BIT]) begin
                            if (!fifo_full) begin
                                push       = 1'b1;
                                n_rx_count = r_rx_count + 1'b1;
                                n_lsr      = n_lsr | u16550rm_pkg::LSR_DR;
                            end
                        end else begin
                            n_lsr = n_lsr | u16550rm_pkg::LSR_TX_EMPTY;
                            n_txv = 1'b1;
                            n_txb = i_write_data;
                        end
                        upd = 1'b1;
                    end
                    u16550rm_pkg::ADDR_IER: begin
                        if (dlab) begin
                            n_dlm = i_write_data;
                        end else begin
                            n_ier = i_write_data[3:0];
                        end
                        upd = 1'b1;
                    end
                    u16550rm_pkg::ADDR_IIR: begin
                        n_fcr = i_write_data;
                        upd   = 1'b1;
                    end
                    u16550rm_pkg::ADDR_LCR: begin
                        n_lcr = i_write_data;
                        upd   = 1'b1;
                    end
                    u16550rm_pkg::ADDR_MCR: begin
                        n_mcr = i_write_data;
                        upd   = 1'b1;
                    end
                    u16550rm_pkg::ADDR_SCR: n_scr = i_write_data;
                    u16550rm_pkg::ADDR_LSR, u16550rm_pkg::ADDR_MSR: begin
                    end
                endcase
            end
            u16550rm_pkg::OP_TICK: begin
                if (r_fcr[u16550rm_pkg::FCR_EN_BIT] && !r_mcr[u16550rm_pkg::MCR_LOOP_BIT]
                        && !fifo_full) begin
                    if (r_backoff != '0 && r_backoff < BW'(u16550rm_pkg::MAX_BACKOFF)) begin
                        n_backoff = r_backoff + 1'b1;
                    end else if (!i_host_byte_valid) begin
                        n_backoff = BW'(1);
                    end else begin
                        n_backoff  = '0;
                        push       = 1'b1;
                        push_data  = i_host_byte;
                        n_rx_count = r_rx_count + 1'b1;
                        n_lsr      = n_lsr | u16550rm_pkg::LSR_DR;
                        n_taken    = 1'b1;
                        upd        = 1'b1;
                    end
                end
            end
            u16550rm_pkg::OP_NONE: begin
            end
        endcase

        // interrupt update with self-clearing fifo control bits
        if (upd) begin
            if (n_fcr[u16550rm_pkg::FCR_RXC_BIT]) begin
                n_fcr[u16550rm_pkg::FCR_RXC_BIT] = 1'b0;
                n_rx_head  = '0;
                n_rx_count = '0;
                n_lsr      = n_lsr & ~u16550rm_pkg::LSR_DR;
            end
            if (n_fcr[u16550rm_pkg::FCR_TXC_BIT]) begin
                n_fcr[u16550rm_pkg::FCR_TXC_BIT] = 1'b0;
                n_lsr = n_lsr | u16550rm_pkg::LSR_TX_EMPTY;
            end
            if (n_ier[u16550rm_pkg::IER_RX_BIT] && (n_lsr[0] == 1'b1)) begin
                pend = pend | u16550rm_pkg::IIR_RX;
            end
            if (n_ier[u16550rm_pkg::IER_TX_BIT] && n_lsr[u16550rm_pkg::LSR_TEMT_BIT]) begin
                pend = pend | u16550rm_pkg::IIR_TX;
            end
            if (pend == '0) begin
                n_iir = u16550rm_pkg::IIR_NONE;
                n_irq = 1'b0;
            end else begin
                n_iir = pend;
                n_irq = 1'b1;
            end
            if (!n_ier[u16550rm_pkg::IER_TX_BIT]) begin
                n_lsr = n_lsr | u16550rm_pkg::LSR_TX_EMPTY;
            end
        end
    end

    u16550rm_ram #(
        .WIDTH (8),
        .DEPTH (u16550rm_pkg::FIFO_DEPTH)
    ) u_rx_fifo (
        .i_clk   (i_clk),
        .i_we    (in_acc && push),
        .i_waddr (push_addr),
        .i_wdata (push_data),
        .i_re    (in_acc && pop),
        .i_raddr (r_rx_head),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head   <= '0;
            r_rx_count  <= '0;
            r_ier       <= '0;
            r_iir       <= u16550rm_pkg::IIR_NONE;
            r_fcr       <= '0;
            r_lcr       <= '0;
            r_mcr       <= u16550rm_pkg::MCR_RESET;
            r_lsr       <= u16550rm_pkg::LSR_TX_EMPTY;
            r_dll       <= u16550rm_pkg::DLL_RESET;
            r_dlm       <= '0;
            r_scr       <= '0;
            r_backoff   <= '0;
            r_irq       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_rx_head   <= n_rx_head;
                r_rx_count  <= n_rx_count;
                r_ier       <= n_ier;
                r_iir       <= n_iir;
                r_fcr       <= n_fcr;
                r_lcr       <= n_lcr;
                r_mcr       <= n_mcr;
                r_lsr       <= n_lsr;
                r_dll       <= n_dll;
                r_dlm       <= n_dlm;
                r_scr       <= n_scr;
                r_backoff   <= n_backoff;
                r_irq       <= n_irq;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd     <= n_rd;
            r_rd_ram <= n_rd_ram;
            r_txv    <= n_txv;
            r_txb    <= n_txb;
            r_taken  <= n_taken;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_read_data       = r_rd_ram ? ram_q : r_rd;
    assign o_irq_level       = r_irq;
    assign o_tx_valid        = r_txv;
    assign o_tx_byte         = r_txb;
    assign o_host_byte_taken = r_taken;

endmodule

[rtl/u16550rm_ram.sv]
module u16550rm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/u16550rm_chk.sv]
`include "uart_16550_register_model_unit_assert.svh"

module u16550rm_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_read_data,
    input logic       o_irq_level,
    input logic       o_tx_valid,
    input logic [7:0] o_tx_byte,
    input logic       o_host_byte_taken
);

    logic        stall;
    logic        res_taken;
    logic [18:0] out_word;

    assign stall     = o_valid && !i_ready;
    assign res_taken = o_valid && o_host_byte_taken;
    assign out_word  = {o_read_data, o_irq_level, o_tx_valid, o_tx_byte, o_host_byte_taken};

    // stalled result transaction holds
    `U16550RM_CHK(a_out_hold, stall |=> o_valid && $stable(out_word), "result changed in stall")

    // no transmitted byte means a zero byte
    `U16550RM_CHK(a_tx_zero, o_valid && !o_tx_valid |-> o_tx_byte == 8'h00, "tx byte without valid")

    // a queued host byte comes from a tick: no read data, no transmit
    `U16550RM_CHK(a_taken_tick, res_taken |-> !o_tx_valid && o_read_data == 8'h00, "taken off a tick")

    // an empty output stage never blocks the input side
    `U16550RM_CHK(a_ready_empty, !o_valid |-> o_ready, "input blocked with empty output")

    // an accepted transaction always yields a result next cycle
    `U16550RM_CHK(a_accept_result, i_valid && o_ready |=> o_valid, "no result after accept")

endmodule

bind uart_16550_register_model_unit u16550rm_chk u_chk (.*);
